>>> rtl/slot_pool_free_and_active_list_top_assert.svh
// Assertion macros for the slot pool. Each macro expects clk and rst_n in scope.
`ifndef SLOT_POOL_FREE_AND_ACTIVE_LIST_TOP_ASSERT_SVH
`define SLOT_POOL_FREE_AND_ACTIVE_LIST_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SPFAL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spfal: implication check failed");
// Next-cycle implication.
`define SPFAL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spfal: next-cycle check failed");
`else
`define SPFAL_ASSERT_IMP(lbl, ante, cons)
`define SPFAL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/spfal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spfal_pkg;

    localparam int SLOTS_DEF  = 32;
    localparam int SLOT_NUM_W = 5;

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DELALL = 2'd3
    } cmd_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_WALK_APP,
        OP_WALK_DEL,
        OP_APPEND,
        OP_PUSH,
        OP_POP,
        OP_FLUSH
    } cell_op_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic tok;
        logic fnd;
    } walk_t;

    // Occupancy of the head cell
    typedef struct packed {
        logic fr_vld;
        logic act_vld;
    } head_t;

endpackage

`default_nettype wire

>>> rtl/spfal_cell.sv
`timescale 1ns / 1ps
`default_nettype none
`include "slot_pool_free_and_active_list_top_assert.svh"

module spfal_cell #(
    parameter int SLOT_W   = 5,
    parameter int CELL_IDX = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire spfal_pkg::cell_op_t  op,
    input  wire logic [SLOT_W-1:0]    key,
    input  wire spfal_pkg::walk_t     walk_in,
    output spfal_pkg::walk_t          walk_out,
    input  wire logic                 lft_fr_vld,
    input  wire logic [SLOT_W-1:0]    lft_fr_slot,
    input  wire logic                 lft_act_vld,
    input  wire logic                 rgt_fr_vld,
    input  wire logic [SLOT_W-1:0]    rgt_fr_slot,
    input  wire logic                 rgt_act_vld,
    input  wire logic [SLOT_W-1:0]    rgt_act_slot,
    output logic                      fr_vld,
    output logic [SLOT_W-1:0]         fr_slot,
    output logic                      act_vld,
    output logic [SLOT_W-1:0]         act_slot
);
    import spfal_pkg::*;

    logic              fr_vld_reg,   fr_vld_next;
    logic [SLOT_W-1:0] fr_slot_reg,  fr_slot_next;
    logic              act_vld_reg,  act_vld_next;
    logic [SLOT_W-1:0] act_slot_reg, act_slot_next;
    walk_t             walk_reg,     walk_next;
    logic              hit_act;
    logic              hit_fr;
    logic              hit;

    always_comb
    begin
        hit_act = act_vld_reg && (act_slot_reg == key);
        hit_fr  = fr_vld_reg && (fr_slot_reg == key);
        // append looks for the slot on both lists, delete only on the active one
        hit     = walk_in.fnd || hit_act || ((op == OP_WALK_APP) && hit_fr);

        walk_next.tok = walk_in.tok;
        walk_next.fnd = walk_in.tok && hit;

        fr_vld_next   = fr_vld_reg;
        fr_slot_next  = fr_slot_reg;
        act_vld_next  = act_vld_reg;
        act_slot_next = act_slot_reg;

        unique case (op)
            OP_POP:
            begin
                fr_vld_next  = rgt_fr_vld;
                fr_slot_next = rgt_fr_slot;
            end
            OP_PUSH:
            begin
                fr_vld_next  = lft_fr_vld;
                fr_slot_next = lft_fr_slot;
            end
            OP_FLUSH:
            begin
                fr_vld_next   = lft_fr_vld;
                fr_slot_next  = lft_fr_slot;
                act_vld_next  = rgt_act_vld;
                act_slot_next = rgt_act_slot;
            end
            OP_APPEND:
            begin
                // only the first empty cell takes the new tail
                if (!act_vld_reg && lft_act_vld)
                begin
                    act_vld_next  = 1'b1;
                    act_slot_next = key;
                end
            end
            OP_WALK_DEL:
            begin
                // close the gap from the match onward
                if (walk_in.tok && (walk_in.fnd || hit_act))
                begin
                    act_vld_next  = rgt_act_vld;
                    act_slot_next = rgt_act_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_vld_reg  <= 1'b1;
            fr_slot_reg <= SLOT_W'(CELL_IDX);
            act_vld_reg <= 1'b0;
            walk_reg    <= '0;
        end
        else
        begin
            fr_vld_reg  <= fr_vld_next;
            fr_slot_reg <= fr_slot_next;
            act_vld_reg <= act_vld_next;
            walk_reg    <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_slot_reg <= act_slot_next;
    end

    assign walk_out = walk_reg;
    assign fr_vld   = fr_vld_reg;
    assign fr_slot  = fr_slot_reg;
    assign act_vld  = act_vld_reg;
    assign act_slot = act_slot_reg;

    // both lists stay packed toward the head cell
    `SPFAL_ASSERT_IMP(a_act_packed, rgt_act_vld, act_vld_reg)
    `SPFAL_ASSERT_IMP(a_fr_packed, rgt_fr_vld, fr_vld_reg)

endmodule

`default_nettype wire

>>> rtl/spfal_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "slot_pool_free_and_active_list_top_assert.svh"

module spfal_ctrl #(
    parameter int SLOTS  = spfal_pkg::SLOTS_DEF,
    parameter int SLOT_W = $clog2(SLOTS)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      cmd,
    input  wire logic [spfal_pkg::SLOT_NUM_W-1:0] slot_number,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [spfal_pkg::SLOT_NUM_W-1:0]     allocated_slot,
    output logic                                 error,
    output logic [spfal_pkg::SLOT_NUM_W-1:0]     active_first,
    output logic                                 active_none,
    input  wire spfal_pkg::head_t                head,
    input  wire logic [SLOT_W-1:0]               head_fr_slot,
    input  wire logic [SLOT_W-1:0]               head_act_slot,
    input  wire spfal_pkg::walk_t                walk_last,
    output spfal_pkg::cell_op_t                  op,
    output spfal_pkg::walk_t                     walk_start,
    output logic [SLOT_W-1:0]                    key,
    output logic [SLOT_W-1:0]                    push_slot
);
    import spfal_pkg::*;

    localparam int KEY_W = ((SLOT_W > SLOT_NUM_W) ? SLOT_W : SLOT_NUM_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WALK,
        ST_FLUSH,
        ST_RESP
    } state_t;

    state_t                 state_reg,  state_next;
    cmd_t                   cmd_reg,    cmd_next;
    logic [SLOT_W-1:0]      key_reg,    key_next;
    logic [SLOT_NUM_W-1:0]  alloc_reg,  alloc_next;
    logic                   err_reg,    err_next;
    logic                   out_valid_reg,  out_valid_next;
    logic [SLOT_NUM_W-1:0]  out_alloc_reg,  out_alloc_next;
    logic                   out_err_reg,    out_err_next;
    logic [SLOT_NUM_W-1:0]  out_first_reg,  out_first_next;
    logic                   out_none_reg,   out_none_next;

    logic                   in_xfer;
    logic [KEY_W-1:0]       key_wide;
    logic                   key_ok;
    cell_op_t               walk_op;

    always_comb
    begin
        in_xfer  = in_valid && (state_reg == ST_IDLE);
        key_wide = KEY_W'(slot_number);
        key_ok   = key_wide < KEY_W'(SLOTS);
        walk_op  = (cmd_reg == CMD_DELETE) ? OP_WALK_DEL : OP_WALK_APP;

        op         = OP_IDLE;
        walk_start = '0;
        push_slot  = (state_reg == ST_FLUSH) ? head_act_slot : key_reg;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        alloc_next     = alloc_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_alloc_next = out_alloc_reg;
        out_err_next   = out_err_reg;
        out_first_next = out_first_reg;
        out_none_next  = out_none_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = cmd_t'(cmd);
                    key_next   = key_wide[SLOT_W-1:0];
                    alloc_next = '0;
                    err_next   = 1'b0;
                    unique case (cmd_t'(cmd)) inside
                        CMD_ALLOC:
                        begin
                            if (head.fr_vld)
                            begin
                                op         = OP_POP;
                                alloc_next = SLOT_NUM_W'(head_fr_slot);
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                            state_next = ST_RESP;
                        end
                        CMD_APPEND, CMD_DELETE:
                        begin
                            if (key_ok)
                            begin
                                state_next = ST_LAUNCH;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = ST_RESP;
                            end
                        end
                        CMD_DELALL:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LAUNCH:
            begin
                op             = walk_op;
                walk_start.tok = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_last.tok)
                begin
                    if (cmd_reg == CMD_APPEND)
                    begin
                        err_next = walk_last.fnd;
                        if (!walk_last.fnd)
                        begin
                            op = OP_APPEND;
                        end
                    end
                    else
                    begin
                        err_next = !walk_last.fnd;
                        if (walk_last.fnd)
                        begin
                            op = OP_PUSH;
                        end
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    op = walk_op;
                end
            end
            ST_FLUSH:
            begin
                if (head.act_vld)
                begin
                    op = OP_FLUSH;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_alloc_next = alloc_reg;
                    out_err_next   = err_reg;
                    out_first_next = head.act_vld ? SLOT_NUM_W'(head_act_slot) : '0;
                    out_none_next  = !head.act_vld;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_ALLOC;
            key_reg       <= '0;
            alloc_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_alloc_reg <= '0;
            out_err_reg   <= 1'b0;
            out_first_reg <= '0;
            out_none_reg  <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            alloc_reg     <= alloc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_alloc_reg <= out_alloc_next;
            out_err_reg   <= out_err_next;
            out_first_reg <= out_first_next;
            out_none_reg  <= out_none_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign key            = key_reg;
    assign out_valid      = out_valid_reg;
    assign allocated_slot = out_alloc_reg;
    assign error          = out_err_reg;
    assign active_first   = out_first_reg;
    assign active_none    = out_none_reg;

    // the token only leaves the chain while a walk is waiting for it
    `SPFAL_ASSERT_IMP(a_tok_in_walk, walk_last.tok, state_reg == ST_WALK)
    // one command in flight at a time
    `SPFAL_ASSERT_NXT(a_one_item, in_xfer, state_reg != ST_IDLE)
    // pop only from a non-empty free list
    `SPFAL_ASSERT_IMP(a_pop_nonempty, op == OP_POP, head.fr_vld)

endmodule

`default_nettype wire

>>> rtl/slot_pool_free_and_active_list_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot pool with a LIFO free list and an ordered active list. The pool is a
// row of SLOTS cells; cell i holds the i-th free-stack entry and the i-th
// active-list entry, so both lists stay packed toward cell 0 (free top and
// active head). Allocate pops the free top. Append and delete send a search
// token down the chain one cell per cycle: append is refused if the slot is
// found on either list (free or already active), delete is refused unless the
// slot is on the active list, and a delete closes the gap behind the token as
// it passes. Delete all moves the active head onto the free top once per
// cycle until the active list is empty. One command is worked on at a time;
// in_stall is high from the transfer until the result is loaded into the
// output register. Allocate and refused out-of-range numbers go straight to
// the result; append and delete wait for the token to leave the last cell,
// and delete all waits until the active list is empty. The output register
// holds a result until it is transferred, and a new command may be accepted
// meanwhile.
module slot_pool_free_and_active_list_top #(
    parameter int SLOTS = spfal_pkg::SLOTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        cmd,
    input  wire logic [spfal_pkg::SLOT_NUM_W-1:0]  slot_number,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [spfal_pkg::SLOT_NUM_W-1:0]       allocated_slot,
    output logic                                   error,
    output logic [spfal_pkg::SLOT_NUM_W-1:0]       active_first,
    output logic                                   active_none
);
    import spfal_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);

    cell_op_t           op;
    walk_t              walk [SLOTS+1];
    head_t              head;
    logic [SLOT_W-1:0]  key;
    logic [SLOT_W-1:0]  push_slot;

    logic               fr_vld   [SLOTS];
    logic [SLOT_W-1:0]  fr_slot  [SLOTS];
    logic               act_vld  [SLOTS];
    logic [SLOT_W-1:0]  act_slot [SLOTS];

    // head status for the sequencer
    assign head.fr_vld  = fr_vld[0];
    assign head.act_vld = act_vld[0];

    spfal_ctrl #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .slot_number    (slot_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .allocated_slot (allocated_slot),
        .error          (error),
        .active_first   (active_first),
        .active_none    (active_none),
        .head           (head),
        .head_fr_slot   (fr_slot[0]),
        .head_act_slot  (act_slot[0]),
        .walk_last      (walk[SLOTS]),
        .op             (op),
        .walk_start     (walk[0]),
        .key            (key),
        .push_slot      (push_slot)
    );

    // Cell chain: the left neighbor of cell 0 is the push source, the right
    // neighbor of the last cell is an empty entry.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic              lft_fr_vld;
        logic [SLOT_W-1:0] lft_fr_slot;
        logic              lft_act_vld;
        logic              rgt_fr_vld;
        logic [SLOT_W-1:0] rgt_fr_slot;
        logic              rgt_act_vld;
        logic [SLOT_W-1:0] rgt_act_slot;

        if (i == 0)
        begin : g_first
            assign lft_fr_vld  = 1'b1;
            assign lft_fr_slot = push_slot;
            assign lft_act_vld = 1'b1;
        end
        else
        begin : g_mid_l
            assign lft_fr_vld  = fr_vld[i-1];
            assign lft_fr_slot = fr_slot[i-1];
            assign lft_act_vld = act_vld[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_last
            assign rgt_fr_vld   = 1'b0;
            assign rgt_fr_slot  = '0;
            assign rgt_act_vld  = 1'b0;
            assign rgt_act_slot = '0;
        end
        else
        begin : g_mid_r
            assign rgt_fr_vld   = fr_vld[i+1];
            assign rgt_fr_slot  = fr_slot[i+1];
            assign rgt_act_vld  = act_vld[i+1];
            assign rgt_act_slot = act_slot[i+1];
        end

        spfal_cell #(
            .SLOT_W   (SLOT_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (op),
            .key          (key),
            .walk_in      (walk[i]),
            .walk_out     (walk[i+1]),
            .lft_fr_vld   (lft_fr_vld),
            .lft_fr_slot  (lft_fr_slot),
            .lft_act_vld  (lft_act_vld),
            .rgt_fr_vld   (rgt_fr_vld),
            .rgt_fr_slot  (rgt_fr_slot),
            .rgt_act_vld  (rgt_act_vld),
            .rgt_act_slot (rgt_act_slot),
            .fr_vld       (fr_vld[i]),
            .fr_slot      (fr_slot[i]),
            .act_vld      (act_vld[i]),
            .act_slot     (act_slot[i])
        );
    end

endmodule

`default_nettype wire
